FILE: rtl/bgf_pkg.sv
// Shared types, constants and helpers for the battery gauge filter.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package bgf_pkg;

   // Default parameter values
   localparam int unsigned ADC_BITS_DEF      = 12;
   localparam int unsigned VOLT_SCALE_DEF    = 1024;
   localparam int unsigned CURR_SCALE_DEF    = 1024;

   // Datapath widths
   localparam int unsigned AVG_W             = 32;   // Q16.16 averages
   localparam int unsigned SCALE_W           = 16;   // Q8 scale factor width
   localparam int unsigned SCALE_FRAC_SHIFT  = 8;    // Q8 scale to Q16.16
   localparam int unsigned SCALED_W          = 40;   // 16-bit ADC * 16-bit scale << 8
   localparam int unsigned QUEUE_DEPTH       = 2;

   // Shared divider
   localparam int unsigned DIV_NUM_W         = 54;
   localparam int unsigned DIV_DEN_W         = 48;
   localparam int unsigned DIV_QUOT_W        = 16;

   // Register port
   localparam int unsigned CSR_INDEX_W       = 3;
   localparam int unsigned CSR_DATA_W        = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_VOLT_ALPHA = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CURR_ALPHA = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_EMPTY_MV   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_FULL_MV    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_CAPACITY   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_REF_MV     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN       = 3'd6;

   localparam logic [15:0] RST_VOLT_ALPHA = 16'd58982;
   localparam logic [15:0] RST_CURR_ALPHA = 16'd58982;
   localparam logic [15:0] RST_EMPTY_MV   = 16'd10500;
   localparam logic [15:0] RST_FULL_MV    = 16'd12600;
   localparam logic [15:0] RST_CAPACITY   = 16'd2200;
   localparam logic [15:0] RST_REF_MV     = 16'd12400;
   localparam logic [15:0] RST_GAIN       = 16'd1;

   localparam logic [5:0]  MINUTES_PER_HOUR = 6'd60;
   localparam logic [6:0]  PERCENT_FULL     = 7'd100;

   typedef struct packed {
      logic             kind;
      logic [AVG_W-1:0] volt;
      logic [AVG_W-1:0] curr;
   } item_type;

   typedef struct packed {
      logic [15:0]        volt_alpha;
      logic [15:0]        curr_alpha;
      logic [15:0]        empty_mv;
      logic [15:0]        full_mv;
      logic [15:0]        capacity;
      logic [15:0]        ref_mv;
      logic signed [15:0] gain;
   } cfg_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic [DIV_QUOT_W-1:0] quot;
   } div_rsp_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   // Clamp a scaled sample to the 32-bit Q16.16 range
   function automatic logic [AVG_W-1:0] scale_saturate(input logic [SCALED_W-1:0] v);
      logic [AVG_W-1:0] r;
      r = (|v[SCALED_W-1:AVG_W]) ? {AVG_W{1'b1}} : v[AVG_W-1:0];
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/bgf_front.sv
// Front end: takes requests, scales the raw ADC codes to Q16.16 and holds
// the item in a stage register until the queue has room. Uses bgf_pkg.
`default_nettype none

module bgf_front #(
   parameter int unsigned ADC_BITS      = bgf_pkg::ADC_BITS_DEF,
   parameter int unsigned VOLT_SCALE_Q8 = bgf_pkg::VOLT_SCALE_DEF,
   parameter int unsigned CURR_SCALE_Q8 = bgf_pkg::CURR_SCALE_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_kind,
   input  wire logic [ADC_BITS-1:0] req_voltage_sample,
   input  wire logic [ADC_BITS-1:0] req_current_sample,
   input  wire logic                q_full,
   output logic                     push,
   output bgf_pkg::item_type        push_item
);
   import bgf_pkg::*;

   localparam logic [SCALE_W-1:0] VSCALE = SCALE_W'(VOLT_SCALE_Q8);
   localparam logic [SCALE_W-1:0] CSCALE = SCALE_W'(CURR_SCALE_Q8);

   logic              stage_valid_ff, stage_valid_in;
   item_type          stage_ff, stage_in;
   logic              accept;
   logic [SCALED_W-1:0] volt_raw, curr_raw;

   assign volt_raw = (SCALED_W'(req_voltage_sample) * SCALED_W'(VSCALE)) << SCALE_FRAC_SHIFT;
   assign curr_raw = (SCALED_W'(req_current_sample) * SCALED_W'(CSCALE)) << SCALE_FRAC_SHIFT;

   assign req_stall = stage_valid_ff && q_full;
   assign accept    = req_valid && !req_stall;
   assign push      = stage_valid_ff && !q_full;
   assign push_item = stage_ff;

   always_comb begin
      stage_in = stage_ff;
      if (accept) begin
         stage_in.kind = req_kind;
         stage_in.volt = scale_saturate(volt_raw);
         stage_in.curr = scale_saturate(curr_raw);
      end
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (push) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

endmodule

`default_nettype wire

FILE: rtl/bgf_queue.sv
// Short FIFO of scaled items between the front end and the sequencer.
// Uses bgf_pkg for the item type and depth.
`default_nettype none

module bgf_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire bgf_pkg::item_type push_item,
   input  wire logic              pop,
   output bgf_pkg::item_type      head,
   output bgf_pkg::queue_stat_type stat
);
   import bgf_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

   item_type          mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign stat.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/bgf_div.sv
// Restoring divider, one quotient bit per cycle, shared by the charge and
// remaining-time divisions. Needs num < den << DIV_QUOT_W. Uses bgf_pkg.
`default_nettype none

module bgf_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bgf_pkg::div_req_type req,
   output bgf_pkg::div_rsp_type      rsp
);
   import bgf_pkg::*;

   localparam int unsigned CNT_W = $clog2(DIV_QUOT_W);
   localparam int unsigned DSH_W = DIV_DEN_W + DIV_QUOT_W - 1;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0]  rem_ff, rem_in;
   logic [DSH_W-1:0]      dsh_ff, dsh_in;
   logic [DIV_QUOT_W-1:0] quot_ff, quot_in;
   logic                  fits;

   assign fits = DSH_W'(rem_ff) >= dsh_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIV_QUOT_W - 1);
         rem_in  = req.num;
         dsh_in  = {req.den, {(DIV_QUOT_W-1){1'b0}}};
         quot_in = '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - dsh_ff[DIV_NUM_W-1:0];
         end
         quot_in = {quot_ff[DIV_QUOT_W-2:0], fits};
         dsh_in  = dsh_ff >> 1;
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;

endmodule

`default_nettype wire

FILE: rtl/bgf_back.sv
// Back end sequencer: filters the averages, derives charge, remaining time
// and motor correction, drives the result register. Uses bgf_pkg, bgf_div.
`default_nettype none

module bgf_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire bgf_pkg::cfg_type        cfg,
   input  wire bgf_pkg::item_type       head,
   input  wire bgf_pkg::queue_stat_type q_stat,
   output logic                         pop,
   output bgf_pkg::div_req_type         div_req,
   input  wire bgf_pkg::div_rsp_type    div_rsp,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [15:0]                  rsp_voltage_avg_mv,
   output logic [15:0]                  rsp_current_avg_ma,
   output logic [6:0]                   rsp_charge_percent,
   output logic [15:0]                  rsp_remaining_minutes,
   output logic signed [31:0]           rsp_motor_correction
);
   import bgf_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_EMA_V0   = 4'd1;
   localparam logic [3:0] S_EMA_V1   = 4'd2;
   localparam logic [3:0] S_EMA_C0   = 4'd3;
   localparam logic [3:0] S_EMA_C1   = 4'd4;
   localparam logic [3:0] S_CLASS    = 4'd5;
   localparam logic [3:0] S_MOTOR    = 4'd6;
   localparam logic [3:0] S_MNUM     = 4'd7;
   localparam logic [3:0] S_MDEN     = 4'd8;
   localparam logic [3:0] S_PCT_GO   = 4'd9;
   localparam logic [3:0] S_PCT_WAIT = 4'd10;
   localparam logic [3:0] S_MIN_GO   = 4'd11;
   localparam logic [3:0] S_MIN_WAIT = 4'd12;
   localparam logic [3:0] S_DONE     = 4'd13;

   localparam logic [1:0] F_ZERO = 2'd0;   // at or below empty
   localparam logic [1:0] F_ONE  = 2'd1;   // at or above full
   localparam logic [1:0] F_FRAC = 2'd2;   // in between

   localparam logic [15:0] MINS_MAX = 16'hFFFF;

   logic [3:0]            state_ff, state_in;
   logic [AVG_W-1:0]      vx_ff, vx_in, cx_ff, cx_in;
   logic [AVG_W-1:0]      vavg_ff, vavg_in, iavg_ff, iavg_in;
   logic [47:0]           acc_ff, acc_in;
   logic [1:0]            fstate_ff, fstate_in;
   logic [AVG_W-1:0]      d_ff, d_in;
   logic [15:0]           span_ff, span_in;
   logic [21:0]           cap60_ff, cap60_in;
   logic signed [48:0]    diff_ff, diff_in;
   logic signed [63:0]    prod_ff, prod_in;
   logic [DIV_NUM_W-1:0]  mnum_ff, mnum_in;
   logic [DIV_DEN_W-1:0]  mden_ff, mden_in;
   logic [6:0]            pct_ff, pct_in;
   logic [15:0]           mins_ff, mins_in;
   logic [31:0]           motor_ff, motor_in;
   logic                  out_valid_ff, out_valid_in;
   logic [15:0]           out_vmv_ff, out_vmv_in, out_ima_ff, out_ima_in;
   logic [6:0]            out_pct_ff, out_pct_in;
   logic [15:0]           out_mins_ff, out_mins_in;
   logic [31:0]           out_motor_ff, out_motor_in;

   logic                  sel_volt;
   logic [AVG_W-1:0]      ema_old, ema_x;
   logic [15:0]           ema_alpha;
   logic [16:0]           ema_w;
   logic [47:0]           ema_prod, ema_sum;
   logic [AVG_W-1:0]      empty16, full16;
   logic signed [64:0]    prod_full;
   logic                  mot_neg;
   logic [63:0]           mot_mag;
   logic [47:0]           mot_shift;
   logic [31:0]           mot_sat;
   logic                  min_sat;
   logic                  out_free;

   // Filter datapath, shared by both channels
   assign sel_volt  = (state_ff == S_EMA_V0) || (state_ff == S_EMA_V1);
   assign ema_old   = sel_volt ? vavg_ff : iavg_ff;
   assign ema_x     = sel_volt ? vx_ff : cx_ff;
   assign ema_alpha = sel_volt ? cfg.volt_alpha : cfg.curr_alpha;
   assign ema_w     = 17'h10000 - {1'b0, ema_alpha};
   assign ema_prod  = 48'(ema_old) * 48'(ema_alpha);
   assign ema_sum   = acc_ff + 48'(ema_x) * 48'(ema_w) + 48'd32768;

   assign empty16   = {cfg.empty_mv, 16'h0000};
   assign full16    = {cfg.full_mv, 16'h0000};

   // Motor correction: truncate toward zero, then clamp to int32
   assign prod_full = 65'(diff_ff) * 65'(cfg.gain);
   assign mot_neg   = prod_ff[63];
   assign mot_mag   = mot_neg ? (64'd0 - $unsigned(prod_ff)) : $unsigned(prod_ff);
   assign mot_shift = mot_mag[63:16];
   always_comb begin
      if (!mot_neg) begin
         mot_sat = (mot_shift > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : mot_shift[31:0];
      end else begin
         mot_sat = (mot_shift > 48'h8000_0000) ? 32'h8000_0000 : mot_shift[31:0];
      end
   end

   assign min_sat  = {10'd0, mnum_ff} >= {mden_ff, 16'h0000};
   assign out_free = !out_valid_ff || !rsp_stall;
   assign pop      = (state_ff == S_IDLE) && !q_stat.empty;

   // Divider operands
   always_comb begin
      div_req.start = 1'b0;
      if (state_ff == S_PCT_GO) begin
         div_req.num = DIV_NUM_W'(d_ff) * DIV_NUM_W'(PERCENT_FULL);
         div_req.den = {16'h0000, span_ff, 16'h0000};
         div_req.start = (fstate_ff == F_FRAC);
      end else begin
         div_req.num = mnum_ff;
         div_req.den = mden_ff;
         div_req.start = (state_ff == S_MIN_GO) && (iavg_ff != '0) &&
                         (fstate_ff != F_ZERO) && !min_sat;
      end
   end

   always_comb begin
      state_in     = state_ff;
      vx_in        = vx_ff;
      cx_in        = cx_ff;
      vavg_in      = vavg_ff;
      iavg_in      = iavg_ff;
      acc_in       = acc_ff;
      fstate_in    = fstate_ff;
      d_in         = d_ff;
      span_in      = span_ff;
      cap60_in     = cap60_ff;
      diff_in      = diff_ff;
      prod_in      = prod_ff;
      mnum_in      = mnum_ff;
      mden_in      = mden_ff;
      pct_in       = pct_ff;
      mins_in      = mins_ff;
      motor_in     = motor_ff;
      out_vmv_in   = out_vmv_ff;
      out_ima_in   = out_ima_ff;
      out_pct_in   = out_pct_ff;
      out_mins_in  = out_mins_ff;
      out_motor_in = out_motor_ff;
      out_valid_in = out_valid_ff && rsp_stall;

      case (state_ff)
         S_IDLE: begin
            if (!q_stat.empty) begin
               vx_in = head.volt;
               cx_in = head.curr;
               if (head.kind) begin
                  state_in = S_EMA_V0;
               end else begin
                  vavg_in  = head.volt;
                  iavg_in  = head.curr;
                  state_in = S_CLASS;
               end
            end
         end
         S_EMA_V0: begin
            acc_in   = ema_prod;
            state_in = S_EMA_V1;
         end
         S_EMA_V1: begin
            vavg_in  = ema_sum[47:16];
            state_in = S_EMA_C0;
         end
         S_EMA_C0: begin
            acc_in   = ema_prod;
            state_in = S_EMA_C1;
         end
         S_EMA_C1: begin
            iavg_in  = ema_sum[47:16];
            state_in = S_CLASS;
         end
         S_CLASS: begin
            if (vavg_ff <= empty16) begin
               fstate_in = F_ZERO;
            end else if (vavg_ff >= full16) begin
               fstate_in = F_ONE;
            end else begin
               fstate_in = F_FRAC;
            end
            d_in     = vavg_ff - empty16;
            span_in  = cfg.full_mv - cfg.empty_mv;
            cap60_in = 22'(cfg.capacity) * 22'(MINUTES_PER_HOUR);
            diff_in  = $signed({1'b0, cfg.ref_mv, 16'h0000}) - $signed({17'd0, vavg_ff});
            state_in = S_MOTOR;
         end
         S_MOTOR: begin
            prod_in  = prod_full[63:0];
            state_in = S_MNUM;
         end
         S_MNUM: begin
            if (fstate_ff == F_ONE) begin
               mnum_in = DIV_NUM_W'({cap60_ff, 16'h0000});
            end else begin
               mnum_in = DIV_NUM_W'(cap60_ff) * DIV_NUM_W'(d_ff);
            end
            state_in = S_MDEN;
         end
         S_MDEN: begin
            if (fstate_ff == F_ONE) begin
               mden_in = DIV_DEN_W'(iavg_ff);
            end else begin
               mden_in = DIV_DEN_W'(span_ff) * DIV_DEN_W'(iavg_ff);
            end
            motor_in = mot_neg ? (32'd0 - mot_sat) : mot_sat;
            state_in = S_PCT_GO;
         end
         S_PCT_GO: begin
            case (fstate_ff)
               F_ZERO: begin
                  pct_in   = 7'd0;
                  state_in = S_MIN_GO;
               end
               F_ONE: begin
                  pct_in   = PERCENT_FULL;
                  state_in = S_MIN_GO;
               end
               default: begin
                  state_in = S_PCT_WAIT;
               end
            endcase
         end
         S_PCT_WAIT: begin
            if (div_rsp.done) begin
               pct_in   = div_rsp.quot[6:0];
               state_in = S_MIN_GO;
            end
         end
         S_MIN_GO: begin
            if (iavg_ff == '0) begin
               mins_in  = MINS_MAX;
               state_in = S_DONE;
            end else if (fstate_ff == F_ZERO) begin
               mins_in  = 16'd0;
               state_in = S_DONE;
            end else if (min_sat) begin
               mins_in  = MINS_MAX;
               state_in = S_DONE;
            end else begin
               state_in = S_MIN_WAIT;
            end
         end
         S_MIN_WAIT: begin
            if (div_rsp.done) begin
               mins_in  = div_rsp.quot;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_vmv_in   = vavg_ff[31:16];
               out_ima_in   = iavg_ff[31:16];
               out_pct_in   = pct_ff;
               out_mins_in  = mins_ff;
               out_motor_in = motor_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         vavg_ff      <= '0;
         iavg_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vavg_ff      <= vavg_in;
         iavg_ff      <= iavg_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      vx_ff        <= vx_in;
      cx_ff        <= cx_in;
      acc_ff       <= acc_in;
      fstate_ff    <= fstate_in;
      d_ff         <= d_in;
      span_ff      <= span_in;
      cap60_ff     <= cap60_in;
      diff_ff      <= diff_in;
      prod_ff      <= prod_in;
      mnum_ff      <= mnum_in;
      mden_ff      <= mden_in;
      pct_ff       <= pct_in;
      mins_ff      <= mins_in;
      motor_ff     <= motor_in;
      out_vmv_ff   <= out_vmv_in;
      out_ima_ff   <= out_ima_in;
      out_pct_ff   <= out_pct_in;
      out_mins_ff  <= out_mins_in;
      out_motor_ff <= out_motor_in;
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_voltage_avg_mv    = out_vmv_ff;
   assign rsp_current_avg_ma    = out_ima_ff;
   assign rsp_charge_percent    = out_pct_ff;
   assign rsp_remaining_minutes = out_mins_ff;
   assign rsp_motor_correction  = $signed(out_motor_ff);

endmodule

`default_nettype wire

FILE: rtl/battery_gauge_filter_top.sv
// Battery gauge filter: voltage/current averaging with charge, remaining
// time and motor correction. Uses bgf_pkg, bgf_front, bgf_queue, bgf_back, bgf_div.
//
// Usage
//  - Request channel (req_*): kind (0 seeds both averages, 1 runs the
//    exponential filter) plus one raw voltage and one raw current ADC code.
//    A request is taken on a clock edge with req_valid high, req_stall low.
//  - Response channel (rsp_*): one response per request, in order, held in
//    an output register. It is taken on an edge with rsp_valid high and
//    rsp_stall low; while stalled it holds still.
//  - Register channel (csr_*): index and 16-bit data, always ready. Write
//    only while no request is in flight. Indexes above 6 are ignored.
//  - Sequencing: the sequencer runs the filter steps on an update, and the
//    charge and remaining-time divisions when they are needed, both on the
//    shared one-bit-per-cycle divider. A request also passes the front
//    stage and the response register on its way to the response.
//  - Front end and queue keep taking requests (up to three waiting) while
//    the sequencer works or the response waits on rsp_stall.
//  - Reset (synchronous, active high) empties the pipe, zeroes the two
//    averages and loads the register defaults.
`default_nettype none

module battery_gauge_filter_top #(
   parameter int unsigned ADC_BITS      = bgf_pkg::ADC_BITS_DEF,
   parameter int unsigned VOLT_SCALE_Q8 = bgf_pkg::VOLT_SCALE_DEF,
   parameter int unsigned CURR_SCALE_Q8 = bgf_pkg::CURR_SCALE_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request channel
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic                            req_kind,
   input  wire logic [ADC_BITS-1:0]             req_voltage_sample,
   input  wire logic [ADC_BITS-1:0]             req_current_sample,
   // response channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [15:0]                          rsp_voltage_avg_mv,
   output logic [15:0]                          rsp_current_avg_ma,
   output logic [6:0]                           rsp_charge_percent,
   output logic [15:0]                          rsp_remaining_minutes,
   output logic signed [31:0]                   rsp_motor_correction,
   // register channel
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [bgf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [bgf_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import bgf_pkg::*;

   cfg_type        cfg_ff, cfg_in;
   logic           push, pop;
   item_type       push_item, head;
   queue_stat_type q_stat;
   div_req_type    div_req;
   div_rsp_type    div_rsp;

   // Register file: writes are always taken
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_VOLT_ALPHA: cfg_in.volt_alpha = csr_wdata;
            REG_CURR_ALPHA: cfg_in.curr_alpha = csr_wdata;
            REG_EMPTY_MV:   cfg_in.empty_mv   = csr_wdata;
            REG_FULL_MV:    cfg_in.full_mv    = csr_wdata;
            REG_CAPACITY:   cfg_in.capacity   = csr_wdata;
            REG_REF_MV:     cfg_in.ref_mv     = csr_wdata;
            REG_GAIN:       cfg_in.gain       = $signed(csr_wdata);
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.volt_alpha <= RST_VOLT_ALPHA;
         cfg_ff.curr_alpha <= RST_CURR_ALPHA;
         cfg_ff.empty_mv   <= RST_EMPTY_MV;
         cfg_ff.full_mv    <= RST_FULL_MV;
         cfg_ff.capacity   <= RST_CAPACITY;
         cfg_ff.ref_mv     <= RST_REF_MV;
         cfg_ff.gain       <= $signed(RST_GAIN);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: scaling and stage register
   bgf_front #(
      .ADC_BITS      (ADC_BITS),
      .VOLT_SCALE_Q8 (VOLT_SCALE_Q8),
      .CURR_SCALE_Q8 (CURR_SCALE_Q8)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_voltage_sample (req_voltage_sample),
      .req_current_sample (req_current_sample),
      .q_full             (q_stat.full),
      .push               (push),
      .push_item          (push_item)
   );

   // Decoupling queue
   bgf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .stat      (q_stat)
   );

   // Shared divider
   bgf_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Sequencer and response register
   bgf_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .cfg                   (cfg_ff),
      .head                  (head),
      .q_stat                (q_stat),
      .pop                   (pop),
      .div_req               (div_req),
      .div_rsp               (div_rsp),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_voltage_avg_mv    (rsp_voltage_avg_mv),
      .rsp_current_avg_ma    (rsp_current_avg_ma),
      .rsp_charge_percent    (rsp_charge_percent),
      .rsp_remaining_minutes (rsp_remaining_minutes),
      .rsp_motor_correction  (rsp_motor_correction)
   );

   // Checks on the block's own logic
   a_div_not_restarted: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   a_queue_state: assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("queue both full and empty");

   a_percent_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_charge_percent <= PERCENT_FULL))
      else $error("charge percent above full scale");

   a_done_single: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |=> !div_rsp.done)
      else $error("divider done held for two cycles");

endmodule

`default_nettype wire

FILE: dv/tb_battery_gauge_filter_top.sv
// Self-checking bench for battery_gauge_filter_top: scoreboard class with its own
// fixed-point model of the gauge, plus request, response and register drivers.
// Depends on rtl/bgf_pkg.sv and the RTL of battery_gauge_filter_top.
`default_nettype none

module tb_battery_gauge_filter_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bgf_pkg::*;

   // Request kinds
   localparam logic KIND_SEED   = 1'b0;
   localparam logic KIND_UPDATE = 1'b1;

   // Index past the last register; the block must ignore writes to it
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 3'd7;

   localparam int unsigned SAMPLE_MAX       = 4095;
   localparam int unsigned ITEMS_PER_PHASE  = 160;
   localparam int unsigned RANDOM_PHASES    = 12;
   localparam int unsigned HOLD_PHASE       = 2;
   localparam int unsigned LONG_HOLD_CYCLES = 300;
   localparam int unsigned SETTLE_CYCLES    = 100;
   localparam int unsigned WATCHDOG_CYCLES  = 4000;

   // Where the filtered voltage sits against the empty/full thresholds
   typedef enum logic [1:0] {BELOW_EMPTY, ABOVE_FULL, PARTIAL} charge_zone_type;

   typedef struct packed {
      logic [15:0]        volt_mv;
      logic [15:0]        curr_ma;
      logic [6:0]         charge;
      logic [15:0]        minutes;
      logic signed [31:0] correction;
   } gauge_reading_type;

   // -----------------------------------------------------------------------
   // Scoreboard: mirrors the register file and both averages, predicts one
   // reading per accepted request and checks readings in order.
   // -----------------------------------------------------------------------
   class gauge_scoreboard;
      cfg_type           cfg;
      logic [31:0]       volt_avg;
      logic [31:0]       curr_avg;
      gauge_reading_type readings_due[$];
      int                errors;

      function new();
         cfg.volt_alpha = RST_VOLT_ALPHA;
         cfg.curr_alpha = RST_CURR_ALPHA;
         cfg.empty_mv   = RST_EMPTY_MV;
         cfg.full_mv    = RST_FULL_MV;
         cfg.capacity   = RST_CAPACITY;
         cfg.ref_mv     = RST_REF_MV;
         cfg.gain       = RST_GAIN;
         volt_avg = '0;
         curr_avg = '0;
         errors   = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index, logic [15:0] data);
         case (index)
            REG_VOLT_ALPHA: cfg.volt_alpha = data;
            REG_CURR_ALPHA: cfg.curr_alpha = data;
            REG_EMPTY_MV:   cfg.empty_mv   = data;
            REG_FULL_MV:    cfg.full_mv    = data;
            REG_CAPACITY:   cfg.capacity   = data;
            REG_REF_MV:     cfg.ref_mv     = data;
            REG_GAIN:       cfg.gain       = data;
            default: ;
         endcase
      endfunction

      // raw code -> Q16.16, clamped to 32 bits
      function logic [31:0] to_q16(logic [11:0] raw, int unsigned scale_q8);
         logic [63:0] v;
         v = (64'(raw) * 64'(scale_q8 & 32'hFFFF)) << 8;
         return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
      endfunction

      // first-order filter, alpha weights the old average, rounds half up
      function logic [31:0] smooth(logic [31:0] avg, logic [31:0] x, logic [15:0] alpha);
         logic [63:0] acc;
         acc = 64'(avg) * 64'(alpha) + 64'(x) * (64'd65536 - 64'(alpha)) + 64'd32768;
         return acc[47:16];
      endfunction

      function int pending();
         return readings_due.size();
      endfunction

      function void note_request(logic kind, logic [11:0] vs, logic [11:0] cs);
         logic [31:0]       vx, cx;
         logic [63:0]       e16, f16, d, span, num, den, mins, mag;
         longint            diff, prod;
         bit                neg;
         charge_zone_type   zone;
         gauge_reading_type r;
         vx = to_q16(vs, VOLT_SCALE_DEF);
         cx = to_q16(cs, CURR_SCALE_DEF);
         if (kind == KIND_SEED) begin
            volt_avg = vx;
            curr_avg = cx;
         end else begin
            volt_avg = smooth(volt_avg, vx, cfg.volt_alpha);
            curr_avg = smooth(curr_avg, cx, cfg.curr_alpha);
         end

         e16  = 64'(cfg.empty_mv) << 16;
         f16  = 64'(cfg.full_mv) << 16;
         d    = '0;
         span = '0;
         // full not above empty: anything over empty counts as full
         if (64'(volt_avg) <= e16) begin
            zone = BELOW_EMPTY;
         end else if (64'(volt_avg) >= f16) begin
            zone = ABOVE_FULL;
         end else begin
            zone = PARTIAL;
            d    = 64'(volt_avg) - e16;
            span = 64'(cfg.full_mv) - 64'(cfg.empty_mv);
         end

         case (zone)
            BELOW_EMPTY: r.charge = 7'd0;
            ABOVE_FULL:  r.charge = 7'd100;
            default:     r.charge = 7'((64'd100 * d) / (span << 16));
         endcase

         // zero current reads as endless time whatever the charge
         if (curr_avg == '0) begin
            mins = 64'd65535;
         end else if (zone == BELOW_EMPTY) begin
            mins = '0;
         end else begin
            if (zone == ABOVE_FULL) begin
               num = 64'd60 * 64'(cfg.capacity) * 64'd65536;
               den = 64'(curr_avg);
            end else begin
               num = 64'd60 * 64'(cfg.capacity) * d;
               den = span * 64'(curr_avg);
            end
            mins = num / den;
            if (mins > 64'd65535) mins = 64'd65535;
         end
         r.minutes = mins[15:0];

         // gain * (reference - average), truncated toward zero, clamped
         diff = longint'(cfg.ref_mv) * 65536 - longint'(volt_avg);
         prod = diff * longint'(cfg.gain);
         neg  = prod < 0;
         mag  = neg ? 64'(-prod) : 64'(prod);
         mag  = mag >> 16;
         if (!neg && mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
         if (neg && mag > 64'h8000_0000) mag = 64'h8000_0000;
         r.correction = neg ? -mag[31:0] : mag[31:0];

         r.volt_mv = volt_avg[31:16];
         r.curr_ma = curr_avg[31:16];
         readings_due.push_back(r);
      endfunction

      function void compare_field(string label, longint want, longint seen);
         if (want != seen) begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, label, want, seen);
         end
      endfunction

      function void check_reading(gauge_reading_type got);
         gauge_reading_type want;
         if (readings_due.size() == 0) begin
            errors++;
            $display("%0t: response with no request outstanding", $time);
            return;
         end
         want = readings_due.pop_front();
         compare_field("voltage_avg_mv", want.volt_mv, got.volt_mv);
         compare_field("current_avg_ma", want.curr_ma, got.curr_ma);
         compare_field("charge_percent", want.charge, got.charge);
         compare_field("remaining_minutes", want.minutes, got.minutes);
         compare_field("motor_correction", want.correction, got.correction);
      endfunction
   endclass

   // -----------------------------------------------------------------------
   // DUT and its connections
   // -----------------------------------------------------------------------
   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic                   req_kind;
   logic [11:0]            req_voltage_sample;
   logic [11:0]            req_current_sample;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [15:0]            rsp_voltage_avg_mv;
   logic [15:0]            rsp_current_avg_ma;
   logic [6:0]             rsp_charge_percent;
   logic [15:0]            rsp_remaining_minutes;
   logic signed [31:0]     rsp_motor_correction;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   battery_gauge_filter_top u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_kind              (req_kind),
      .req_voltage_sample    (req_voltage_sample),
      .req_current_sample    (req_current_sample),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_voltage_avg_mv    (rsp_voltage_avg_mv),
      .rsp_current_avg_ma    (rsp_current_avg_ma),
      .rsp_charge_percent    (rsp_charge_percent),
      .rsp_remaining_minutes (rsp_remaining_minutes),
      .rsp_motor_correction  (rsp_motor_correction),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   gauge_scoreboard ledger;

   // Per-phase idle ceilings for each side; 0 gives a back-to-back stretch
   int unsigned req_idle_max = 8;
   int unsigned rsp_idle_max = 8;
   // Set by the main sequence to make the response side sit on rsp_stall
   bit          hold_armed   = 1'b0;
   int unsigned quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // -----------------------------------------------------------------------
   // Watchdog: counts cycles without any handshake on any channel
   // -----------------------------------------------------------------------
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      wait (quiet_cycles >= WATCHDOG_CYCLES);
      $display("%0t: timeout, no handshake for %0d cycles", $time, WATCHDOG_CYCLES);
      $display("tb_battery_gauge_filter_top failed");
      $finish;
   end

   // -----------------------------------------------------------------------
   // Request side. Each task is entered and left at a falling edge, so a
   // back-to-back request keeps req_valid high with a single assignment.
   // -----------------------------------------------------------------------
   task automatic offer_samples(input logic kind, input logic [11:0] vs,
                                input logic [11:0] cs);
      int unsigned gap;
      gap = $urandom_range(0, req_idle_max);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_kind           <= kind;
      req_voltage_sample <= vs;
      req_current_sample <= cs;
      req_valid          <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ledger.note_request(kind, vs, cs);
      @(negedge clock);
   endtask

   // Drop valid and wait until every request has come back as a response.
   // Each request yields exactly one response, so the block is idle then.
   task automatic drain_pipe();
      req_valid <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Write the whole register file; optionally poke the unused index too
   task automatic program_gauge(input cfg_type c, input bit poke_unused);
      logic [CSR_INDEX_W-1:0] idx [8];
      logic [15:0]            val [8];
      int unsigned            count;
      idx = '{REG_VOLT_ALPHA, REG_CURR_ALPHA, REG_EMPTY_MV, REG_FULL_MV,
              REG_CAPACITY, REG_REF_MV, REG_GAIN, REG_UNUSED};
      val = '{c.volt_alpha, c.curr_alpha, c.empty_mv, c.full_mv,
              c.capacity, c.ref_mv, c.gain, 16'hFFFF};
      count = poke_unused ? 8 : 7;
      for (int i = 0; i < count; i++) begin
         csr_index <= idx[i];
         csr_wdata <= val[i];
         csr_valid <= 1'b1;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         ledger.write_register(idx[i], val[i]);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   function automatic cfg_type setup_of(logic [15:0] va, logic [15:0] ca, logic [15:0] e,
                                        logic [15:0] f, logic [15:0] cap, logic [15:0] r,
                                        logic [15:0] g);
      cfg_type c;
      c.volt_alpha = va;
      c.curr_alpha = ca;
      c.empty_mv   = e;
      c.full_mv    = f;
      c.capacity   = cap;
      c.ref_mv     = r;
      c.gain       = g;
      return c;
   endfunction

   // Mostly within the useful range, now and then an end of the field
   function automatic logic [15:0] spread_u16(int unsigned lo, int unsigned hi);
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom_range(lo, hi));
      endcase
   endfunction

   function automatic cfg_type random_setup();
      cfg_type c;
      c.volt_alpha = spread_u16(49152, 65535);
      c.curr_alpha = spread_u16(49152, 65535);
      // thresholds within the span that 12-bit samples reach (4 mV a code)
      c.empty_mv   = spread_u16(0, 4 * SAMPLE_MAX);
      c.full_mv    = spread_u16(0, 4 * SAMPLE_MAX);
      if (c.full_mv < c.empty_mv && $urandom_range(0, 3) != 0)
         {c.full_mv, c.empty_mv} = {c.empty_mv, c.full_mv};
      c.capacity   = spread_u16(0, 10000);
      c.ref_mv     = spread_u16(0, 4 * SAMPLE_MAX);
      case ($urandom_range(0, 7))
         0:       c.gain = 16'h8000;
         1:       c.gain = 16'h7FFF;
         default: c.gain = 16'($urandom_range(0, 64)) - 16'd32;
      endcase
      return c;
   endfunction

   function automatic logic [11:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return 12'd0;
         1:       return 12'(SAMPLE_MAX);
         default: return 12'($urandom_range(0, SAMPLE_MAX));
      endcase
   endfunction

   // -----------------------------------------------------------------------
   // Response side: random stall before each response, plus one long hold
   // so the queue fills and the block pushes back on the request side.
   // -----------------------------------------------------------------------
   initial begin : response_side
      int unsigned       pause;
      gauge_reading_type got;
      rsp_stall = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (hold_armed) begin
            hold_armed = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
         end
         pause = $urandom_range(0, rsp_idle_max);
         if (pause != 0) begin
            rsp_stall <= 1'b1;
            repeat (pause) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         got.volt_mv    = rsp_voltage_avg_mv;
         got.curr_ma    = rsp_current_avg_ma;
         got.charge     = rsp_charge_percent;
         got.minutes    = rsp_remaining_minutes;
         got.correction = rsp_motor_correction;
         ledger.check_reading(got);
      end
   end

   // -----------------------------------------------------------------------
   // Main sequence
   // -----------------------------------------------------------------------
   initial begin : main_sequence
      cfg_type     setup;
      logic        kind;
      logic [11:0] vs;
      logic [11:0] cs;

      reset              = 1'b1;
      req_valid          = 1'b0;
      req_kind           = KIND_SEED;
      req_voltage_sample = '0;
      req_current_sample = '0;
      csr_valid          = 1'b0;
      csr_index          = REG_VOLT_ALPHA;
      csr_wdata          = '0;
      ledger             = new();

      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset register values: empty is 10500 mV (code 2625), full is
      // 12600 mV (code 3150). Exactly at empty with zero current first.
      offer_samples(KIND_SEED,   12'd2625, 12'd0);
      offer_samples(KIND_SEED,   12'd3150, 12'd100);    // exactly at full
      offer_samples(KIND_SEED,   12'd2624, 12'd4095);   // just below empty
      offer_samples(KIND_SEED,   12'd3151, 12'd1);      // just above full
      offer_samples(KIND_SEED,   12'd2900, 12'd500);    // part charged
      offer_samples(KIND_UPDATE, 12'd2900, 12'd500);
      offer_samples(KIND_SEED,   12'd0,    12'd0);
      offer_samples(KIND_SEED,   12'd4095, 12'd4095);
      offer_samples(KIND_UPDATE, 12'd0,    12'd4095);
      offer_samples(KIND_UPDATE, 12'd4095, 12'd0);
      drain_pipe();

      // Full below empty, alpha extremes, largest capacity, most negative
      // gain; also check that the spare index is ignored.
      program_gauge(setup_of(16'd0, 16'hFFFF, 16'd12000, 16'd11000, 16'hFFFF,
                             16'd0, 16'h8000), 1'b1);
      offer_samples(KIND_SEED,   12'd3000, 12'd1);      // at empty
      offer_samples(KIND_SEED,   12'd3001, 12'd1);      // over empty reads full
      offer_samples(KIND_UPDATE, 12'd2999, 12'd4095);
      offer_samples(KIND_UPDATE, 12'd4095, 12'd0);
      drain_pipe();

      // Other ends of every field
      program_gauge(setup_of(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd0,
                             16'hFFFF, 16'h7FFF), 1'b0);
      offer_samples(KIND_SEED,   12'd0,    12'd0);
      offer_samples(KIND_SEED,   12'd4095, 12'd4095);
      offer_samples(KIND_UPDATE, 12'd1,    12'd1);
      drain_pipe();

      // Full equal to empty
      program_gauge(setup_of(16'd32768, 16'd32768, 16'd10000, 16'd10000, 16'd1,
                             16'd16380, 16'hFFFF), 1'b0);
      offer_samples(KIND_SEED,   12'd2500, 12'd10);
      offer_samples(KIND_SEED,   12'd2501, 12'd10);
      offer_samples(KIND_UPDATE, 12'd2500, 12'd0);
      drain_pipe();

      // Random phases, fresh register settings each time
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         setup = random_setup();
         program_gauge(setup, 1'b0);
         req_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
         rsp_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
         if (p == HOLD_PHASE) begin
            // requests back to back while the response side sits still
            req_idle_max = 0;
            hold_armed   = 1'b1;
         end
         repeat (ITEMS_PER_PHASE) begin
            kind = ($urandom_range(0, 4) == 0) ? KIND_SEED : KIND_UPDATE;
            vs   = pick_sample();
            cs   = ($urandom_range(0, 7) == 0) ? 12'd0 : pick_sample();
            offer_samples(kind, vs, cs);
         end
         drain_pipe();
      end

      // Anything stray would show up here as an unexpected response
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (ledger.errors == 0)
         $display("tb_battery_gauge_filter_top passed");
      else
         $display("tb_battery_gauge_filter_top failed");
      $finish;
   end

endmodule

`default_nettype wire
